// ===== rtl/bpa_pkg.sv =====
// Shared types, constants and reset values of the bitmap page allocator.
`default_nettype none
package bpa_pkg;

  localparam int unsigned POOL_PAGES_DEF = 4096;
  localparam int unsigned MAX_RUN_DEF    = 64;

  localparam logic [31:0] KPBASE_RST = 32'h0020_0000;
  localparam logic [31:0] UPBASE_RST = 32'h0110_0000;
  localparam logic [12:0] KPAGES_RST = 13'd3840;
  localparam logic [12:0] UPAGES_RST = 13'd3840;
  localparam logic [31:0] KVBASE_RST = 32'hc010_0000;
  localparam logic [31:0] UVBASE_RST = 32'h0804_8000;

  typedef enum logic [1:0] {
    REQ_ALLOC = 2'd0,
    REQ_FREE  = 2'd1,
    REQ_XLAT  = 2'd2
  } req_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NO_VIRT = 2'd1,
    ST_NO_PHYS = 2'd2,
    ST_OUTSIDE = 2'd3
  } st_t;

  typedef enum logic [2:0] {
    RG_KPBASE = 3'd0,
    RG_UPBASE = 3'd1,
    RG_KPAGES = 3'd2,
    RG_UPAGES = 3'd3,
    RG_KVBASE = 3'd4,
    RG_UVBASE = 3'd5
  } reg_idx_t;

  typedef enum logic [3:0] {
    OP_NONE    = 4'd0,
    OP_CLEAR   = 4'd1,
    OP_LOAD    = 4'd2,
    OP_V_CHK   = 4'd3,
    OP_MARK    = 4'd4,
    OP_P_CHK   = 4'd5,
    OP_F_CHECK = 4'd6,
    OP_F_MAP   = 4'd7,
    OP_F_REL   = 4'd8,
    OP_T_CHECK = 4'd9,
    OP_T_OUT   = 4'd10
  } op_t;

  typedef struct packed {
    logic [31:0] kpbase;
    logic [31:0] upbase;
    logic [12:0] kpages;
    logic [12:0] upages;
    logic [31:0] kvbase;
    logic [31:0] uvbase;
  } cfg_t;

  typedef struct packed {
    op_t  op;
    logic emit;
    st_t  st;
  } cmd_t;

  typedef struct packed {
    logic clr_done;
    logic idx_end;
    logic run_hit;
    logic page_last;
    logic f_end;
    logic p_used;
    logic free_bad;
    logic xlat_bad;
  } dpstat_t;

endpackage
`default_nettype wire

// ===== rtl/bpa_cfg.sv =====
// Configuration register file behind the APB-style port.
`default_nettype none
module bpa_cfg (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         psel,
  input  wire logic         penable,
  input  wire logic         pwrite,
  input  wire logic [4:0]   paddr,
  input  wire logic [31:0]  pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output bpa_pkg::cfg_t     cfg
);
  import bpa_pkg::*;

  cfg_t     cfg_r;
  cfg_t     cfg_nxt;
  reg_idx_t ridx;
  logic     wr_en;

  assign ridx   = reg_idx_t'(paddr[4:2]);
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (ridx)
        RG_KPBASE: cfg_nxt.kpbase = pwdata;
        RG_UPBASE: cfg_nxt.upbase = pwdata;
        RG_KPAGES: cfg_nxt.kpages = pwdata[12:0];
        RG_UPAGES: cfg_nxt.upages = pwdata[12:0];
        RG_KVBASE: cfg_nxt.kvbase = pwdata;
        RG_UVBASE: cfg_nxt.uvbase = pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (ridx)
      RG_KPBASE: prdata = cfg_r.kpbase;
      RG_UPBASE: prdata = cfg_r.upbase;
      RG_KPAGES: prdata = {19'd0, cfg_r.kpages};
      RG_UPAGES: prdata = {19'd0, cfg_r.upages};
      RG_KVBASE: prdata = cfg_r.kvbase;
      RG_UVBASE: prdata = cfg_r.uvbase;
      default:   prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.kpbase <= KPBASE_RST;
      cfg_r.upbase <= UPBASE_RST;
      cfg_r.kpages <= KPAGES_RST;
      cfg_r.upages <= UPAGES_RST;
      cfg_r.kvbase <= KVBASE_RST;
      cfg_r.uvbase <= UVBASE_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/bpa_datapath.sv =====
// Bitmaps, mapping table, scan counters and result register of the allocator.
`default_nettype none
module bpa_datapath #(
  parameter int unsigned POOL_PAGES = bpa_pkg::POOL_PAGES_DEF,
  parameter int unsigned MAX_RUN    = bpa_pkg::MAX_RUN_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire bpa_pkg::cfg_t  cfg,
  input  wire bpa_pkg::cmd_t  cmd,
  input  wire logic           in_pool_select,
  input  wire logic [6:0]     in_page_count,
  input  wire logic [31:0]    in_virt_addr,
  output bpa_pkg::dpstat_t    st,
  output logic                out_valid,
  output logic [1:0]          out_status,
  output logic [31:0]         out_virt_out,
  output logic [31:0]         out_phys_out,
  output logic                out_present,
  output logic                out_last
);
  import bpa_pkg::*;

  localparam int unsigned PW    = $clog2(POOL_PAGES);
  localparam int unsigned IW    = $clog2(POOL_PAGES + 1);
  localparam int unsigned AW    = PW + 1;
  localparam int unsigned DEPTH = 1 << AW;
  localparam int unsigned CW    = $clog2(MAX_RUN + 1);

  // Both pools share each memory; the pool bit is the top address bit.
  logic        vmem [DEPTH];
  logic        pmem [DEPTH];
  logic [20:0] mmem [DEPTH];

  logic        vmem_rd, pmem_rd;
  logic [20:0] mmem_rd;

  logic          pool_r;
  logic [CW-1:0] cnt_r;
  logic [31:0]   va_r;
  logic [IW-1:0] idx_r;
  logic [CW-1:0] run_r;
  logic [PW-1:0] start_r;
  logic [CW-1:0] i_r;
  logic [IW-1:0] f_r;
  logic [20:0]   e_r;
  logic [AW-1:0] clr_r;

  logic          ov_r;
  logic [1:0]    os_r;
  logic [31:0]   ova_r, opa_r;
  logic          opr_r, ol_r;

  logic [IW-1:0] n_k, n_u, n_sel;
  logic [31:0]   vbase, pbase;
  logic [PW-1:0] vidx_cur;
  logic [31:0]   va_page, pa_new;
  logic [31:0]   vdiff;
  logic [19:0]   vidx20;
  logic [6:0]    cnt_in;
  logic [31:0]   pa_rel, pdiff;
  logic          ppool;
  logic [19:0]   pidx;
  logic [IW-1:0] n_rel;
  logic          rel_ok;

  logic          v_we, p_we, m_we;
  logic [AW-1:0] v_wa, p_wa, m_wa, m_ra;
  logic          v_wd, p_wd;
  logic [20:0]   m_wd;

  function automatic logic [IW-1:0] pool_len(input logic [12:0] pages);
    if (32'(pages) > POOL_PAGES) begin
      pool_len = IW'(POOL_PAGES);
    end else begin
      pool_len = IW'(pages);
    end
  endfunction

  assign n_k      = pool_len(cfg.kpages);
  assign n_u      = pool_len(cfg.upages);
  assign n_sel    = pool_r ? n_u : n_k;
  assign vbase    = pool_r ? cfg.uvbase : cfg.kvbase;
  assign pbase    = pool_r ? cfg.upbase : cfg.kpbase;
  assign vidx_cur = PW'(start_r + PW'(i_r));
  assign va_page  = vbase + (32'(vidx_cur) << 12);
  assign pa_new   = pbase + (32'(f_r[PW-1:0]) << 12);
  assign vdiff    = va_r - vbase;
  assign vidx20   = vdiff[31:12];

  // Page count 0 counts as one page; counts above the run limit are clipped.
  always_comb begin
    if (in_page_count == 7'd0) begin
      cnt_in = 7'd1;
    end else if (32'(in_page_count) > MAX_RUN) begin
      cnt_in = 7'(MAX_RUN);
    end else begin
      cnt_in = in_page_count;
    end
  end

  // The physical pool of a released frame follows from its address.
  assign pa_rel = {e_r[19:0], 12'd0};
  assign ppool  = pa_rel >= cfg.upbase;
  assign pdiff  = pa_rel - (ppool ? cfg.upbase : cfg.kpbase);
  assign pidx   = pdiff[31:12];
  assign n_rel  = ppool ? n_u : n_k;
  assign rel_ok = pidx < 20'(n_rel);

  assign st.clr_done  = &clr_r;
  assign st.idx_end   = idx_r >= n_sel;
  assign st.run_hit   = !vmem_rd && (CW'(run_r + 1'b1) == cnt_r);
  assign st.page_last = CW'(i_r + 1'b1) == cnt_r;
  assign st.f_end     = f_r >= n_sel;
  assign st.p_used    = pmem_rd;
  assign st.xlat_bad  = vidx20 >= 20'(n_sel);
  assign st.free_bad  = (vidx20 >= 20'(n_sel)) ||
                        ((21'(vidx20) + 21'(cnt_r)) > 21'(n_sel));

  always_comb begin
    v_we = 1'b0;
    v_wa = {pool_r, vidx_cur};
    v_wd = 1'b0;
    p_we = 1'b0;
    p_wa = {pool_r, f_r[PW-1:0]};
    p_wd = 1'b1;
    m_we = 1'b0;
    m_wa = {pool_r, vidx_cur};
    m_wd = {1'b1, pa_new[31:12]};
    m_ra = (cmd.op == OP_T_CHECK) ? {pool_r, vidx20[PW-1:0]} : {pool_r, vidx_cur};
    case (cmd.op)
      OP_CLEAR: begin
        v_we = 1'b1;
        v_wa = clr_r;
        p_we = 1'b1;
        p_wa = clr_r;
        p_wd = 1'b0;
        m_we = 1'b1;
        m_wa = clr_r;
        m_wd = 21'd0;
      end
      OP_MARK: begin
        v_we = 1'b1;
        v_wd = 1'b1;
      end
      OP_P_CHK: begin
        p_we = !pmem_rd;
        m_we = !pmem_rd;
      end
      OP_F_MAP: begin
        v_we = 1'b1;
        m_we = 1'b1;
        m_wd = {1'b0, mmem_rd[19:0]};
      end
      OP_F_REL: begin
        p_we = e_r[20] && rel_ok;
        p_wa = {ppool, pidx[PW-1:0]};
        p_wd = 1'b0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (v_we) begin
      vmem[v_wa] <= v_wd;
    end
    vmem_rd <= vmem[{pool_r, idx_r[PW-1:0]}];
  end

  always_ff @(posedge clk) begin
    if (p_we) begin
      pmem[p_wa] <= p_wd;
    end
    pmem_rd <= pmem[{pool_r, f_r[PW-1:0]}];
  end

  always_ff @(posedge clk) begin
    if (m_we) begin
      mmem[m_wa] <= m_wd;
    end
    mmem_rd <= mmem[m_ra];
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        pool_r <= in_pool_select;
        cnt_r  <= CW'(cnt_in);
        va_r   <= in_virt_addr;
        idx_r  <= '0;
        run_r  <= '0;
        i_r    <= '0;
        f_r    <= '0;
      end
      OP_V_CHK: begin
        if (vmem_rd) begin
          run_r <= '0;
        end else begin
          if (run_r == '0) begin
            start_r <= idx_r[PW-1:0];
          end
          run_r <= CW'(run_r + 1'b1);
        end
        idx_r <= IW'(idx_r + 1'b1);
      end
      OP_MARK: begin
        if (st.page_last) begin
          i_r <= '0;
          f_r <= '0;
        end else begin
          i_r <= CW'(i_r + 1'b1);
        end
      end
      OP_P_CHK: begin
        if (!pmem_rd) begin
          i_r <= CW'(i_r + 1'b1);
          f_r <= '0;
        end else begin
          f_r <= IW'(f_r + 1'b1);
        end
      end
      OP_F_CHECK: begin
        start_r <= vidx20[PW-1:0];
        i_r     <= '0;
      end
      OP_F_MAP: e_r <= mmem_rd;
      OP_F_REL: i_r <= CW'(i_r + 1'b1);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r <= '0;
    end else if (cmd.op == OP_CLEAR) begin
      clr_r <= AW'(clr_r + 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else begin
      ov_r <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      os_r <= cmd.st;
      case (cmd.st)
        ST_NO_VIRT: begin
          ova_r <= 32'd0;
          opa_r <= 32'd0;
          opr_r <= 1'b0;
          ol_r  <= 1'b1;
        end
        ST_NO_PHYS: begin
          ova_r <= va_page;
          opa_r <= 32'd0;
          opr_r <= 1'b0;
          ol_r  <= 1'b1;
        end
        ST_OUTSIDE: begin
          ova_r <= va_r;
          opa_r <= 32'd0;
          opr_r <= 1'b0;
          ol_r  <= 1'b1;
        end
        default: begin
          if (cmd.op == OP_P_CHK) begin
            ova_r <= va_page;
            opa_r <= pa_new;
            opr_r <= 1'b1;
            ol_r  <= st.page_last;
          end else if (cmd.op == OP_T_OUT) begin
            ova_r <= va_r;
            opa_r <= {mmem_rd[19:0], va_r[11:0]};
            opr_r <= mmem_rd[20];
            ol_r  <= 1'b1;
          end else begin
            ova_r <= va_r;
            opa_r <= 32'd0;
            opr_r <= 1'b0;
            ol_r  <= 1'b1;
          end
        end
      endcase
    end
  end

  assign out_valid    = ov_r;
  assign out_status   = os_r;
  assign out_virt_out = ova_r;
  assign out_phys_out = opa_r;
  assign out_present  = opr_r;
  assign out_last     = ol_r;

endmodule
`default_nettype wire

// ===== rtl/bpa_ctrl.sv =====
// Sequencer of the allocator: clearing pass, allocate, free and translate.
`default_nettype none
module bpa_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [1:0]       in_req_type,
  input  wire bpa_pkg::dpstat_t st,
  output logic                  busy,
  output bpa_pkg::cmd_t         cmd
);
  import bpa_pkg::*;

  typedef enum logic [12:0] {
    S_CLEAR   = 13'b0_0000_0000_0001,
    S_IDLE    = 13'b0_0000_0000_0010,
    S_A_VRD   = 13'b0_0000_0000_0100,
    S_A_VCHK  = 13'b0_0000_0000_1000,
    S_A_MARK  = 13'b0_0000_0001_0000,
    S_A_PRD   = 13'b0_0000_0010_0000,
    S_A_PCHK  = 13'b0_0000_0100_0000,
    S_F_CHECK = 13'b0_0000_1000_0000,
    S_F_RD    = 13'b0_0001_0000_0000,
    S_F_MAP   = 13'b0_0010_0000_0000,
    S_F_REL   = 13'b0_0100_0000_0000,
    S_T_CHECK = 13'b0_1000_0000_0000,
    S_T_OUT   = 13'b1_0000_0000_0000
  } state_t;

  state_t state_r, state_nxt;

  assign busy = state_r != S_IDLE;

  always_comb begin
    state_nxt = state_r;
    cmd.op    = OP_NONE;
    cmd.emit  = 1'b0;
    cmd.st    = ST_OK;
    unique case (state_r)
      S_CLEAR: begin
        cmd.op = OP_CLEAR;
        if (st.clr_done) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          cmd.op = OP_LOAD;
          unique case (req_t'(in_req_type))
            REQ_ALLOC: state_nxt = S_A_VRD;
            REQ_FREE:  state_nxt = S_F_CHECK;
            REQ_XLAT:  state_nxt = S_T_CHECK;
            default:   state_nxt = S_IDLE;
          endcase
        end
      end
      S_A_VRD: begin
        if (st.idx_end) begin
          cmd.emit  = 1'b1;
          cmd.st    = ST_NO_VIRT;
          state_nxt = S_IDLE;
        end else begin
          state_nxt = S_A_VCHK;
        end
      end
      S_A_VCHK: begin
        cmd.op    = OP_V_CHK;
        state_nxt = st.run_hit ? S_A_MARK : S_A_VRD;
      end
      S_A_MARK: begin
        cmd.op = OP_MARK;
        if (st.page_last) state_nxt = S_A_PRD;
      end
      S_A_PRD: begin
        if (st.f_end) begin
          cmd.emit  = 1'b1;
          cmd.st    = ST_NO_PHYS;
          state_nxt = S_IDLE;
        end else begin
          state_nxt = S_A_PCHK;
        end
      end
      S_A_PCHK: begin
        cmd.op = OP_P_CHK;
        if (!st.p_used) begin
          cmd.emit  = 1'b1;
          state_nxt = st.page_last ? S_IDLE : S_A_PRD;
        end else begin
          state_nxt = S_A_PRD;
        end
      end
      S_F_CHECK: begin
        cmd.op = OP_F_CHECK;
        if (st.free_bad) begin
          cmd.emit  = 1'b1;
          cmd.st    = ST_OUTSIDE;
          state_nxt = S_IDLE;
        end else begin
          state_nxt = S_F_RD;
        end
      end
      S_F_RD:  state_nxt = S_F_MAP;
      S_F_MAP: begin
        cmd.op    = OP_F_MAP;
        state_nxt = S_F_REL;
      end
      S_F_REL: begin
        cmd.op = OP_F_REL;
        if (st.page_last) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          state_nxt = S_F_RD;
        end
      end
      S_T_CHECK: begin
        cmd.op = OP_T_CHECK;
        if (st.xlat_bad) begin
          cmd.emit  = 1'b1;
          cmd.st    = ST_OUTSIDE;
          state_nxt = S_IDLE;
        end else begin
          state_nxt = S_T_OUT;
        end
      end
      S_T_OUT: begin
        cmd.op    = OP_T_OUT;
        cmd.emit  = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/bitmap_page_allocator_top.sv =====
// Top level of the bitmap page allocator: register file, sequencer and datapath.
//
//   channel   ports                              transfer
//   request   start, busy, in_*                  start high while busy is low
//   result    out_valid, out_*                   out_valid high for one cycle
//   config    psel, penable, pwrite, paddr, ...  APB access phase, pready high
//
// After reset the block sweeps 2**(clog2(POOL_PAGES)+1) entries to clear the bitmaps
// and the mapping table, with busy high; configuration writes are taken meanwhile.
// Allocate checks the virtual bitmap bit by bit, marks each page of the run, and for
// each page checks physical bits until a free frame; the single-bit bitmap read ports
// set this pace. Free checks the range, then frees each page; translate checks, then
// answers. Results are strobed and cannot be stalled; one request is worked on at a time.
`default_nettype none
module bitmap_page_allocator_top #(
  parameter int unsigned POOL_PAGES = bpa_pkg::POOL_PAGES_DEF,
  parameter int unsigned MAX_RUN    = bpa_pkg::MAX_RUN_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  in_req_type,
  input  wire logic        in_pool_select,
  input  wire logic [6:0]  in_page_count,
  input  wire logic [31:0] in_virt_addr,
  output logic             out_valid,
  output logic [1:0]       out_status,
  output logic [31:0]      out_virt_out,
  output logic [31:0]      out_phys_out,
  output logic             out_present,
  output logic             out_last,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import bpa_pkg::*;

  cfg_t    cfg;
  cmd_t    cmd;
  dpstat_t st;

  bpa_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  bpa_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .in_req_type (in_req_type),
    .st          (st),
    .busy        (busy),
    .cmd         (cmd)
  );

  bpa_datapath #(
    .POOL_PAGES (POOL_PAGES),
    .MAX_RUN    (MAX_RUN)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg),
    .cmd            (cmd),
    .in_pool_select (in_pool_select),
    .in_page_count  (in_page_count),
    .in_virt_addr   (in_virt_addr),
    .st             (st),
    .out_valid      (out_valid),
    .out_status     (out_status),
    .out_virt_out   (out_virt_out),
    .out_phys_out   (out_phys_out),
    .out_present    (out_present),
    .out_last       (out_last)
  );

endmodule
`default_nettype wire
